FILE: hw/rtl/tas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tas_pkg
// Shared types and constants for the triangle adjacency store.
// ----------------------------------------------------------------------------
package tas_pkg;

  localparam int unsigned NodeCount = 1024;
  localparam int unsigned ListDepth = 64;
  localparam int unsigned NodeW     = 10;
  localparam int unsigned RowW      = (NodeCount > 1) ? $clog2(NodeCount) : 1;
  localparam int unsigned IdxW      = (ListDepth > 1) ? $clog2(ListDepth) : 1;
  localparam int unsigned CntW      = $clog2(ListDepth + 1);
  localparam int unsigned AddrW     = RowW + IdxW;
  localparam int unsigned EntryW    = 2 * NodeW;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_DEL     = 3'd2,
    OP_QUERY   = 3'd3,
    OP_ADD_TRI = 3'd4,
    OP_DEL_TRI = 3'd5,
    OP_COUNT   = 3'd6,
    OP_NONE    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SUB,      // set up one pair sub-operation
    S_CNT,      // count read data available
    S_SCAN_RD,  // issue entry read
    S_SCAN_CK,  // compare read entry
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH,   // write count, next sub-op
    S_RESP
  } state_e;

endpackage

FILE: hw/rtl/triangle_adjacency_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_adjacency_store_top
// Per-node ordered lists of unordered node pairs with push, pop, delete,
// query, triangle add/delete and count read, on one shared entry memory.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake           | Word
// in      | in  | in_valid_i/ready_o  | operation, node_a, node_b, node_c
// out     | out | out_valid_o/ready_i | status, found, position, entry_count,
//         |     |                     | changed
//
// One word at a time. A pair sub-operation scans its list entry by entry, a
// read then a compare per entry, and compaction reads each following entry
// and writes it one slot down, all through the single entry memory port; a
// triangle op runs three sub-ops. After reset a clearing pass over the
// NodeCount list counters runs before the first word.
// The result is held in an output register until taken.
// ----------------------------------------------------------------------------
module triangle_adjacency_store_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] operation_i,
  input  logic [9:0] node_a_i,
  input  logic [9:0] node_b_i,
  input  logic [9:0] node_c_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic       found_o,
  output logic [5:0] position_o,
  output logic [6:0] entry_count_o,
  output logic [1:0] changed_o
);

  localparam int unsigned RowW  = tas_pkg::RowW;
  localparam int unsigned IdxW  = tas_pkg::IdxW;
  localparam int unsigned CntW  = tas_pkg::CntW;
  localparam int unsigned NodeW = tas_pkg::NodeW;

  tas_pkg::state_e state_q, state_d;

  // item registers
  logic [2:0]       op_q;
  logic [NodeW-1:0] a_q, b_q, c_q;
  logic [1:0]       sub_q, sub_d;
  logic [1:0]       stat_q, stat_d;
  logic [1:0]       chg_q, chg_d;
  logic             fnd_q, fnd_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  cnt_q, cnt_d;    // count of current list
  logic [CntW-1:0]  idx_q, idx_d;    // scan / shift pointer
  logic [RowW-1:0]  clr_q, clr_d;
  logic             clr_last_q;

  // output register
  logic [1:0] o_stat_q;
  logic       o_fnd_q;
  logic [5:0] o_pos_q;
  logic [6:0] o_cnt_q;
  logic [1:0] o_chg_q;

  // memories
  logic [CntW-1:0]   cnt_mem [tas_pkg::NodeCount];
  logic [tas_pkg::EntryW-1:0] ent_mem [tas_pkg::NodeCount * tas_pkg::ListDepth];
  logic [CntW-1:0]   cnt_rd_q;
  logic [tas_pkg::EntryW-1:0] ent_rd_q;

  // current sub-operation pair
  logic [NodeW-1:0] row_node, px, py;
  logic [RowW-1:0]  row;
  logic             remove_op, add_op;

  always_comb begin
    row_node = a_q;
    px = b_q;
    py = c_q;
    unique case (sub_q)
      2'd1: begin row_node = b_q; px = c_q; py = a_q; end
      2'd2: begin row_node = c_q; px = b_q; py = a_q; end
      default: ;
    endcase
  end
  assign row = row_node[RowW-1:0];
  assign remove_op = (op_q == tas_pkg::OP_DEL) || (op_q == tas_pkg::OP_DEL_TRI);
  assign add_op    = (op_q == tas_pkg::OP_PUSH) || (op_q == tas_pkg::OP_ADD_TRI);

  logic match;
  logic [NodeW-1:0] ep, eq;
  assign ep = ent_rd_q[NodeW-1:0];
  assign eq = ent_rd_q[2*NodeW-1:NodeW];
  assign match = ((ep == px) && (eq == py)) || ((ep == py) && (eq == px));

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign in_ready_o  = (state_q == tas_pkg::S_IDLE);
  assign out_valid_o = (state_q == tas_pkg::S_RESP);

  logic last_sub;
  assign last_sub = (op_q == tas_pkg::OP_ADD_TRI || op_q == tas_pkg::OP_DEL_TRI)
                    ? (sub_q == 2'd2) : 1'b1;

  // memory control
  logic            cnt_we, ent_we, ent_re;
  logic [CntW-1:0] cnt_wd;
  logic [RowW-1:0] cnt_wa;
  logic [CntW-1:0] ent_idx;
  logic [tas_pkg::EntryW-1:0] ent_wd;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tas_pkg::S_CLEAR:  if (clr_last_q) state_d = tas_pkg::S_IDLE;
      tas_pkg::S_IDLE:   if (in_acc) state_d = tas_pkg::S_SUB;
      tas_pkg::S_SUB:    state_d = tas_pkg::S_CNT;
      tas_pkg::S_CNT: begin
        priority if (op_q == tas_pkg::OP_PUSH || op_q == tas_pkg::OP_POP ||
                     op_q == tas_pkg::OP_COUNT || op_q == tas_pkg::OP_NONE)
          state_d = tas_pkg::S_FINISH;
        else if (cnt_rd_q == '0) state_d = tas_pkg::S_FINISH;
        else state_d = tas_pkg::S_SCAN_RD;
      end
      tas_pkg::S_SCAN_RD: state_d = tas_pkg::S_SCAN_CK;
      tas_pkg::S_SCAN_CK: begin
        priority if (match && remove_op) state_d = tas_pkg::S_SHIFT_RD;
        else if (match || idx_q + 1'b1 >= cnt_q) state_d = tas_pkg::S_FINISH;
        else state_d = tas_pkg::S_SCAN_RD;
      end
      tas_pkg::S_SHIFT_RD: begin
        if (idx_q + 1'b1 >= cnt_q) state_d = tas_pkg::S_FINISH;
        else state_d = tas_pkg::S_SHIFT_WR;
      end
      tas_pkg::S_SHIFT_WR: state_d = tas_pkg::S_SHIFT_RD;
      tas_pkg::S_FINISH:  state_d = last_sub ? tas_pkg::S_RESP : tas_pkg::S_SUB;
      tas_pkg::S_RESP:    if (out_acc) state_d = tas_pkg::S_IDLE;
      default:            state_d = tas_pkg::S_IDLE;
    endcase
  end

  // datapath / outputs of the sequencer
  always_comb begin
    sub_d = sub_q; stat_d = stat_q; chg_d = chg_q; fnd_d = fnd_q;
    pos_d = pos_q; cnt_d = cnt_q; idx_d = idx_q; clr_d = clr_q;
    cnt_we = 1'b0; cnt_wa = row; cnt_wd = cnt_q;
    ent_we = 1'b0; ent_re = 1'b0; ent_idx = idx_q; ent_wd = ent_rd_q;
    unique case (state_q)
      tas_pkg::S_CLEAR: begin
        cnt_we = 1'b1; cnt_wa = clr_q; cnt_wd = '0;
        clr_d = clr_q + 1'b1;
      end
      tas_pkg::S_IDLE: begin
        sub_d = '0; stat_d = tas_pkg::ST_OK; chg_d = '0; fnd_d = 1'b0; pos_d = '0;
      end
      tas_pkg::S_SUB: idx_d = '0;
      tas_pkg::S_CNT: begin
        cnt_d = cnt_rd_q;
        idx_d = '0;
        if (op_q == tas_pkg::OP_PUSH) begin
          // pushed in FINISH
        end else if (op_q == tas_pkg::OP_POP) begin
          if (cnt_rd_q == '0) stat_d = tas_pkg::ST_EMPTY;
          else begin cnt_d = cnt_rd_q - 1'b1; chg_d = 2'd1; end
        end
      end
      tas_pkg::S_SCAN_RD: ent_re = 1'b1;
      tas_pkg::S_SCAN_CK: begin
        if (match) begin
          if (op_q == tas_pkg::OP_QUERY) begin
            fnd_d = 1'b1; pos_d = idx_q[IdxW-1:0];
          end
        end else idx_d = idx_q + 1'b1;
      end
      tas_pkg::S_SHIFT_RD: begin
        ent_re = 1'b1; ent_idx = idx_q + 1'b1;
      end
      tas_pkg::S_SHIFT_WR: begin
        ent_we = 1'b1; ent_wd = ent_rd_q; idx_d = idx_q + 1'b1;
      end
      tas_pkg::S_FINISH: begin
        // idx_q points at match (last entry after a compaction), or count when scan missed
        priority if (op_q == tas_pkg::OP_POP) begin
          cnt_we = 1'b1;
        end else if (add_op) begin
          if (op_q == tas_pkg::OP_ADD_TRI && cnt_q != '0 && idx_q < cnt_q) begin
            // already present
          end else if (cnt_q >= CntW'(tas_pkg::ListDepth)) begin
            stat_d = tas_pkg::ST_FULL;
          end else begin
            ent_we = 1'b1; ent_idx = cnt_q; ent_wd = {py, px};
            cnt_we = 1'b1; cnt_wd = cnt_q + 1'b1; cnt_d = cnt_q + 1'b1;
            chg_d = chg_q + 1'b1;
          end
        end else if (remove_op) begin
          if (cnt_q != '0 && idx_q < cnt_q) begin
            cnt_we = 1'b1; cnt_wd = cnt_q - 1'b1; cnt_d = cnt_q - 1'b1;
            chg_d = chg_q + 1'b1;
          end else stat_d = tas_pkg::ST_NOTFOUND;
        end else begin
        end
        sub_d = sub_q + 1'b1;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_q <= cnt_mem[row];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[{row, ent_idx[IdxW-1:0]}] <= ent_wd;
    if (ent_re) ent_rd_q <= ent_mem[{row, ent_idx[IdxW-1:0]}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tas_pkg::S_CLEAR;
      clr_q <= '0;
      clr_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      clr_last_q <= (state_q == tas_pkg::S_CLEAR) && (clr_q == RowW'(tas_pkg::NodeCount - 2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= operation_i; a_q <= node_a_i; b_q <= node_b_i; c_q <= node_c_i;
    end
    sub_q <= sub_d; stat_q <= stat_d; chg_q <= chg_d; fnd_q <= fnd_d;
    pos_q <= pos_d; cnt_q <= cnt_d; idx_q <= idx_d;
    if (state_q == tas_pkg::S_FINISH && last_sub) begin
      o_stat_q <= stat_d;
      o_fnd_q  <= fnd_q;
      o_pos_q  <= 6'(pos_q);
      o_chg_q  <= chg_d;
      // this is the last sub-op's list, list a for pair ops; a later sub-op may hit the same row
      o_cnt_q  <= 7'(cnt_d);
    end
  end

  // list a count for triangle ops: track separately
  logic [CntW-1:0] a_cnt_q;
  always_ff @(posedge clk_i) begin
    if (state_q == tas_pkg::S_FINISH && row == a_q[RowW-1:0]) a_cnt_q <= cnt_d;
  end

  assign status_o      = o_stat_q;
  assign found_o       = o_fnd_q;
  assign position_o    = o_pos_q;
  assign entry_count_o = (op_q == tas_pkg::OP_ADD_TRI || op_q == tas_pkg::OP_DEL_TRI)
                         ? 7'(a_cnt_q) : o_cnt_q;
  assign changed_o     = o_chg_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tas_pkg::S_FINISH |-> cnt_q <= CntW'(tas_pkg::ListDepth))
    else $error("count overflow");
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_found_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == tas_pkg::ST_OK) else $error("found bad");

endmodule
